FILE: design/bbw_pkg.sv
// bbw_pkg: shared types and constants of the bilinear backward warp unit
// no dependencies; imported by the top level, bbw_front and bbw_back

package bbw_pkg;

	// default store geometry
	localparam int unsigned DEF_MAX_WIDTH  = 256;
	localparam int unsigned DEF_MAX_HEIGHT = 256;

	// entries in the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_INV_SPACING_X = 2'd2;
	localparam logic [1:0] REG_INV_SPACING_Y = 2'd3;

	// register reset values
	localparam logic [8:0]  RST_IMAGE_WIDTH  = 9'd256;
	localparam logic [8:0]  RST_IMAGE_HEIGHT = 9'd256;
	localparam logic [11:0] RST_INV_SPACING  = 12'd256;

	// item codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// fixed-width part of one queued item
	typedef struct packed {
		logic        is_query;
		logic        oor;
		logic        ld_ok;
		logic        nx_ok;
		logic        ny_ok;
		logic [7:0]  fx;
		logic [7:0]  fy;
		logic [15:0] pixel;
	} bbw_ctrl_t;

endpackage

FILE: design/bilinear_backward_warp_unit.sv
// bilinear_backward_warp_unit: top level, configuration registers and glue
// depends on bbw_pkg, bbw_front, bbw_queue and bbw_back

// Load transactions (action 0) write one 16-bit sample of the second image into
// a frame store split into four banks by column and row parity; query
// transactions (action 1) return one result each, the bilinear blend of the
// four neighbours around pos + disp * inv_spacing, or zero with out_of_range
// set when the sample point is outside the image. One transaction is taken
// per cycle while the queue is not full: the four banks give all four
// neighbours in a single read, and the multipliers are pipelined. The front
// and back are parted by a four-entry queue, so a stalled output does not
// block input until that queue is full. Stored samples are undefined until
// loaded; there is no clearing pass. Configuration writes are to be made
// while the block is idle.

module bilinear_backward_warp_unit import bbw_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [15:0] pixel_value,
	input  logic [15:0] disp_x,
	input  logic [15:0] disp_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] warped_value,
	output logic        out_of_range
);

	localparam int unsigned XB = $clog2(MAX_WIDTH);
	localparam int unsigned YB = $clog2(MAX_HEIGHT);
	localparam int unsigned CTW = $bits(bbw_ctrl_t);
	localparam int unsigned QW  = CTW + XB + YB;

	logic [8:0]  image_width_q, image_height_q;
	logic [11:0] inv_x_q, inv_y_q;

	logic          push, pop, full, empty;
	bbw_ctrl_t     push_ctrl, head_ctrl;
	logic [XB-1:0] push_ix, head_ix;
	logic [YB-1:0] push_iy, head_iy;
	logic [QW-1:0] head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			inv_x_q        <= RST_INV_SPACING;
			inv_y_q        <= RST_INV_SPACING;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   image_width_q  <= cfg_data[8:0];
				REG_IMAGE_HEIGHT:  image_height_q <= cfg_data[8:0];
				REG_INV_SPACING_X: inv_x_q        <= cfg_data;
				REG_INV_SPACING_Y: inv_y_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	bbw_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.XB        (XB),
		.YB        (YB)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.inv_spacing_x(inv_x_q),
		.inv_spacing_y(inv_y_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pixel_value  (pixel_value),
		.disp_x       (disp_x),
		.disp_y       (disp_y),
		.push         (push),
		.push_ctrl    (push_ctrl),
		.push_ix      (push_ix),
		.push_iy      (push_iy),
		.queue_full   (full)
	);

	bbw_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctrl, push_ix, push_iy}),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	// unpack queue head
	assign head_ctrl = head[QW-1 -: CTW];
	assign head_ix   = head[YB +: XB];
	assign head_iy   = head[YB-1:0];

	bbw_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.XB        (XB),
		.YB        (YB)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head_ctrl   (head_ctrl),
		.head_ix     (head_ix),
		.head_iy     (head_iy),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.warped_value(warped_value),
		.out_of_range(out_of_range)
	);

endmodule

FILE: design/bbw_ram.sv
// bbw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module bbw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/bbw_queue.sv
// bbw_queue: small fifo decoupling the front and back parts
// no dependencies

module bbw_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = buf_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/bbw_front.sv
// bbw_front: accepts transactions, scales displacements and classifies them
// depends on bbw_pkg

module bbw_front import bbw_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int unsigned XB = $clog2(MAX_WIDTH),
	parameter int unsigned YB = $clog2(MAX_HEIGHT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [8:0]    image_width,
	input  logic [8:0]    image_height,
	input  logic [11:0]   inv_spacing_x,
	input  logic [11:0]   inv_spacing_y,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          action,
	input  logic [7:0]    pos_x,
	input  logic [7:0]    pos_y,
	input  logic [15:0]   pixel_value,
	input  logic [15:0]   disp_x,
	input  logic [15:0]   disp_y,
	output logic          push,
	output bbw_ctrl_t     push_ctrl,
	output logic [XB-1:0] push_ix,
	output logic [YB-1:0] push_iy,
	input  logic          queue_full
);

	localparam int unsigned WXB = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
	localparam int unsigned WYB = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
	localparam int unsigned LB  = (WXB > WYB) ? WXB : WYB;
	localparam int unsigned SW  = (LB + 9 > 22) ? LB + 9 : 22;

	logic               v_s1, act_s1;
	logic [7:0]         px_s1, py_s1;
	logic [15:0]        pix_s1;
	logic signed [28:0] prx_s1, pry_s1;
	logic signed [28:0] prx, pry;
	logic               adv;

	logic [WXB-1:0]       w_c;
	logic [WYB-1:0]       h_c;
	logic signed [SW-1:0] sx, sy, lim_x, lim_y;
	logic [XB-1:0]        ix;
	logic [YB-1:0]        iy;
	logic                 oor, ld_ok;

	// displacement times reciprocal spacing, Q.16
	assign prx = $signed(disp_x) * $signed({1'b0, inv_spacing_x});
	assign pry = $signed(disp_y) * $signed({1'b0, inv_spacing_y});

	assign push     = v_s1 && !queue_full;
	assign in_ready = !v_s1 || !queue_full;
	assign adv      = in_ready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			act_s1 <= action;
			px_s1  <= pos_x;
			py_s1  <= pos_y;
			pix_s1 <= pixel_value;
			prx_s1 <= prx;
			pry_s1 <= pry;
		end
	end

	// image size clamped to the store
	always_comb begin
		if (image_width == '0) begin
			w_c = WXB'(1);
		end else if (WXB'(image_width) > WXB'(MAX_WIDTH)) begin
			w_c = WXB'(MAX_WIDTH);
		end else begin
			w_c = WXB'(image_width);
		end
		if (image_height == '0) begin
			h_c = WYB'(1);
		end else if (WYB'(image_height) > WYB'(MAX_HEIGHT)) begin
			h_c = WYB'(MAX_HEIGHT);
		end else begin
			h_c = WYB'(image_height);
		end
	end

	// sample point in Q.8, floored displacement, and range test
	always_comb begin
		sx    = $signed({{(SW - 16){1'b0}}, px_s1, 8'd0}) + SW'(prx_s1 >>> 8);
		sy    = $signed({{(SW - 16){1'b0}}, py_s1, 8'd0}) + SW'(pry_s1 >>> 8);
		lim_x = $signed({{(SW - WXB - 8){1'b0}}, w_c - 1'b1, 8'd0});
		lim_y = $signed({{(SW - WYB - 8){1'b0}}, h_c - 1'b1, 8'd0});
		oor   = sx[SW-1] || sy[SW-1] || (sx > lim_x) || (sy > lim_y);
		ld_ok = (32'(px_s1) < MAX_WIDTH) && (32'(py_s1) < MAX_HEIGHT);
		if (act_s1 == ACT_QUERY) begin
			ix = sx[8 +: XB];
			iy = sy[8 +: YB];
		end else begin
			ix = XB'(px_s1);
			iy = YB'(py_s1);
		end
	end

	// queue entry
	always_comb begin
		push_ctrl.is_query = (act_s1 == ACT_QUERY);
		push_ctrl.oor      = oor;
		push_ctrl.ld_ok    = ld_ok;
		push_ctrl.nx_ok    = (WXB'(ix) + 1'b1) < w_c;
		push_ctrl.ny_ok    = (WYB'(iy) + 1'b1) < h_c;
		push_ctrl.fx       = sx[7:0];
		push_ctrl.fy       = sy[7:0];
		push_ctrl.pixel    = pix_s1;
		push_ix            = ix;
		push_iy            = iy;
	end

endmodule

FILE: design/bbw_back.sv
// bbw_back: banked frame store, neighbour fetch, blend and output register
// depends on bbw_pkg and bbw_ram

module bbw_back import bbw_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int unsigned XB = $clog2(MAX_WIDTH),
	parameter int unsigned YB = $clog2(MAX_HEIGHT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  bbw_ctrl_t     head_ctrl,
	input  logic [XB-1:0] head_ix,
	input  logic [YB-1:0] head_iy,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [15:0]   warped_value,
	output logic          out_of_range
);

	localparam int unsigned HXB   = (XB > 1) ? XB - 1 : 1;
	localparam int unsigned HYB   = (YB > 1) ? YB - 1 : 1;
	localparam int unsigned DEPTH = 2 ** (HXB + HYB);
	localparam int unsigned AW    = HXB + HYB;

	logic        adv;
	logic        rd_en, wr_en;
	logic [XB:0] cx0, cx1;
	logic [YB:0] ry0, ry1;
	logic [AW-1:0] raddr [4];
	logic [AW-1:0] waddr;
	logic [3:0]    bank_we;
	logic [15:0]   rdata [4];
	logic [8:0]    gx, gy, hx, hy;

	logic        v_s1, oor_s1, ix0_s1, iy0_s1, nx_s1, ny_s1;
	logic [16:0] w_s1 [4];
	logic [15:0] nb [4];

	logic        v_s2, oor_s2;
	logic [31:0] p_s2 [4];
	logic [33:0] sum;

	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign adv       = !out_valid_q || out_ready;
	assign pop       = adv && !empty;
	assign rd_en     = pop && head_ctrl.is_query && !head_ctrl.oor;
	assign wr_en     = pop && !head_ctrl.is_query && head_ctrl.ld_ok;

	// candidate columns and rows: bank parity picks ix or ix+1
	assign cx0 = {1'b0, head_ix};
	assign cx1 = {1'b0, head_ix} + 1'b1;
	assign ry0 = {1'b0, head_iy};
	assign ry1 = {1'b0, head_iy} + 1'b1;

	// bank index is {row parity, column parity}
	always_comb begin
		logic [XB:0] c;
		logic [YB:0] r;
		for (int b = 0; b < 4; b++) begin
			c = (head_ix[0] == b[0]) ? cx0 : cx1;
			r = (head_iy[0] == b[1]) ? ry0 : ry1;
			raddr[b]   = {r[HYB:1], c[HXB:1]};
			bank_we[b] = wr_en && (head_ix[0] == b[0]) && (head_iy[0] == b[1]);
		end
		waddr = {ry0[HYB:1], cx0[HXB:1]};
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		bbw_ram #(
			.WIDTH(16),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (bank_we[b]),
			.waddr(waddr),
			.wdata(head_ctrl.pixel),
			.re   (rd_en),
			.raddr(raddr[b]),
			.rdata(rdata[b])
		);
	end

	// blend weights
	assign gx = 9'd256 - {1'b0, head_ctrl.fx};
	assign hx = {1'b0, head_ctrl.fx};
	assign gy = 9'd256 - {1'b0, head_ctrl.fy};
	assign hy = {1'b0, head_ctrl.fy};

	// fetch stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop && head_ctrl.is_query;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			oor_s1 <= head_ctrl.oor;
			ix0_s1 <= head_ix[0];
			iy0_s1 <= head_iy[0];
			nx_s1  <= head_ctrl.nx_ok;
			ny_s1  <= head_ctrl.ny_ok;
			w_s1[0] <= 17'(gx * gy);
			w_s1[1] <= 17'(hx * gy);
			w_s1[2] <= 17'(gx * hy);
			w_s1[3] <= 17'(hx * hy);
		end
	end

	// neighbours in (dx, dy) order, past the edge reads as zero
	always_comb begin
		nb[0] = rdata[{iy0_s1, ix0_s1}];
		nb[1] = nx_s1 ? rdata[{iy0_s1, !ix0_s1}] : 16'd0;
		nb[2] = ny_s1 ? rdata[{!iy0_s1, ix0_s1}] : 16'd0;
		nb[3] = (nx_s1 && ny_s1) ? rdata[{!iy0_s1, !ix0_s1}] : 16'd0;
	end

	// weighted products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			oor_s2 <= oor_s1;
			for (int k = 0; k < 4; k++) begin
				p_s2[k] <= 32'(w_s1[k] * nb[k]);
			end
		end
	end

	assign sum = 34'(p_s2[0]) + 34'(p_s2[1]) + 34'(p_s2[2]) + 34'(p_s2[3]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			warped_value <= oor_s2 ? 16'd0 : sum[31:16];
			out_of_range <= oor_s2;
		end
	end

endmodule
